>>> rtl/core/iirf_pkg.sv
// Shared constants for the IIR frequency-response block.
// CORDIC angle table, fixed stage counts, register indexes, reset values and saturation limits.
// No dependencies.
package iirf_pkg;

    localparam int TURN_BITS    = 32;
    localparam int CORDIC_ITERS = 30;
    localparam int CORDIC_FRAC  = 30;
    localparam int TRIG_W       = 34;
    localparam int QUOT_BITS    = 33;

    localparam int TRIG_LAT = TURN_BITS + 1 + CORDIC_ITERS + 1;
    localparam int DIV_LAT  = 1 + QUOT_BITS + 1;

    localparam logic signed [TRIG_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [TRIG_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [TRIG_W-1:0] HALF_TURN = 34'sd2147483648;

    localparam int ATAN_TURN [CORDIC_ITERS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
        10, 5, 3, 1
    };

    localparam int REG_BIN_COUNT = 0;
    localparam int REG_COEF_BASE = 1;

    localparam int          BIN_COUNT_RESET = 1025;
    localparam logic [63:0] COEF0_RESET     = 64'h0000_0000_1000_0000;

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

endpackage

>>> rtl/core/iirf_trig.sv
// Angle to cos/sin unit: turn division by the bin count, then pipelined CORDIC.
// Uses iirf_pkg. One item per clock.
module iirf_trig
    import iirf_pkg::*;
#(
    parameter int BIN_WIDTH = 13
)(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic [BIN_WIDTH:0]       n,
    input  logic [BIN_WIDTH-1:0]     bc,
    output logic                     out_valid,
    output logic signed [TRIG_W-1:0] cos_val,
    output logic signed [TRIG_W-1:0] sin_val
);

    localparam int NW = BIN_WIDTH + 1;

    logic                 dv_reg [TURN_BITS];
    logic [NW-1:0]        dr_reg [TURN_BITS];
    logic [TURN_BITS-1:0] dq_reg [TURN_BITS];

    genvar s;
    for (s = 0; s < TURN_BITS; s++) begin : g_turn
        logic [NW-1:0]        r_in;
        logic [TURN_BITS-1:0] q_in;
        logic                 v_in;
        logic                 ge;
        if (s == 0) begin : g_first
            assign r_in = n;
            assign q_in = '0;
            assign v_in = in_valid;
        end else begin : g_rest
            assign r_in = {dr_reg[s-1][NW-2:0], 1'b0};
            assign q_in = dq_reg[s-1];
            assign v_in = dv_reg[s-1];
        end
        assign ge = r_in >= NW'(bc);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[s] <= 1'b0;
            else
                dv_reg[s] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            dr_reg[s] <= ge ? r_in - NW'(bc) : r_in;
            dq_reg[s] <= {q_in[TURN_BITS-2:0], ge};
        end
    end

    // fold turns beyond a quarter onto the right half plane
    logic                     fv_reg;
    logic signed [TRIG_W-1:0] fz_reg;
    logic                     ff_reg;
    logic signed [TRIG_W-1:0] z0;

    assign z0 = TRIG_W'($signed(dq_reg[TURN_BITS-1]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg <= 1'b0;
        else
            fv_reg <= dv_reg[TURN_BITS-1];
    end

    always_ff @(posedge clk)
    begin
        if (z0 > QUARTER_TURN)
        begin
            fz_reg <= z0 - HALF_TURN;
            ff_reg <= 1'b1;
        end
        else if (z0 < -QUARTER_TURN)
        begin
            fz_reg <= z0 + HALF_TURN;
            ff_reg <= 1'b1;
        end
        else
        begin
            fz_reg <= z0;
            ff_reg <= 1'b0;
        end
    end

    logic                     cv_reg [CORDIC_ITERS];
    logic signed [TRIG_W-1:0] cx_reg [CORDIC_ITERS];
    logic signed [TRIG_W-1:0] cy_reg [CORDIC_ITERS];
    logic signed [TRIG_W-1:0] cz_reg [CORDIC_ITERS];
    logic                     cf_reg [CORDIC_ITERS];

    genvar i;
    for (i = 0; i < CORDIC_ITERS; i++) begin : g_cordic
        logic signed [TRIG_W-1:0] x_in, y_in, z_in, dx, dy, at;
        logic                     f_in, v_in;
        if (i == 0) begin : g_first
            assign x_in = CORDIC_GAIN;
            assign y_in = '0;
            assign z_in = fz_reg;
            assign f_in = ff_reg;
            assign v_in = fv_reg;
        end else begin : g_rest
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign z_in = cz_reg[i-1];
            assign f_in = cf_reg[i-1];
            assign v_in = cv_reg[i-1];
        end
        assign dx = y_in >>> i;
        assign dy = x_in >>> i;
        assign at = TRIG_W'(ATAN_TURN[i]);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i] <= 1'b0;
            else
                cv_reg[i] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            cf_reg[i] <= f_in;
            if (!z_in[TRIG_W-1])
            begin
                cx_reg[i] <= x_in - dx;
                cy_reg[i] <= y_in + dy;
                cz_reg[i] <= z_in - at;
            end
            else
            begin
                cx_reg[i] <= x_in + dx;
                cy_reg[i] <= y_in - dy;
                cz_reg[i] <= z_in + at;
            end
        end
    end

    logic                     ov_reg;
    logic signed [TRIG_W-1:0] oc_reg;
    logic signed [TRIG_W-1:0] os_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= cv_reg[CORDIC_ITERS-1];
    end

    always_ff @(posedge clk)
    begin
        oc_reg <= cf_reg[CORDIC_ITERS-1] ? -cx_reg[CORDIC_ITERS-1] : cx_reg[CORDIC_ITERS-1];
        os_reg <= cf_reg[CORDIC_ITERS-1] ? -cy_reg[CORDIC_ITERS-1] : cy_reg[CORDIC_ITERS-1];
    end

    assign out_valid = ov_reg;
    assign cos_val   = oc_reg;
    assign sin_val   = os_reg;

endmodule

>>> rtl/core/iirf_div.sv
// Two-lane pipelined restoring divider: sign * floor(num * 2^FRAC_BITS / den),
// saturated to 32 bits. Uses iirf_pkg.
module iirf_div
    import iirf_pkg::*;
#(
    parameter int NUM_W     = 80,
    parameter int DEN_W     = 79,
    parameter int FRAC_BITS = 28,
    parameter int TAG_W     = 14
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [1:0]       neg,
    input  logic [NUM_W-1:0] num [2],
    input  logic [DEN_W-1:0] den,
    input  logic [TAG_W-1:0] tag_in,
    output logic             out_valid,
    output logic [31:0]      quot [2],
    output logic [TAG_W-1:0] tag_out
);

    localparam int RW = NUM_W + FRAC_BITS + QUOT_BITS + 1;
    localparam int NS = QUOT_BITS + 1;

    logic                 v_reg   [NS];
    logic [DEN_W-1:0]     den_reg [NS];
    logic [TAG_W-1:0]     tag_reg [NS];
    logic [RW-1:0]        rem_reg [2][NS];
    logic [QUOT_BITS-1:0] q_reg   [2][NS];
    logic                 ovf_reg [2][NS];
    logic                 neg_reg [2][NS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        den_reg[0] <= den;
        tag_reg[0] <= tag_in;
    end

    genvar l, s;
    for (l = 0; l < 2; l++) begin : g_lane
        logic [RW-1:0] n_sh;
        assign n_sh = RW'(num[l]) << FRAC_BITS;
        always_ff @(posedge clk)
        begin
            rem_reg[l][0] <= n_sh;
            q_reg[l][0]   <= '0;
            ovf_reg[l][0] <= n_sh >= (RW'(den) << QUOT_BITS);
            neg_reg[l][0] <= neg[l];
        end
        for (s = 1; s < NS; s++) begin : g_step
            logic [RW-1:0] dsh;
            logic          ge;
            assign dsh = RW'(den_reg[s-1]) << (QUOT_BITS - s);
            assign ge  = rem_reg[l][s-1] >= dsh;
            always_ff @(posedge clk)
            begin
                rem_reg[l][s] <= ge ? rem_reg[l][s-1] - dsh : rem_reg[l][s-1];
                q_reg[l][s]   <= {q_reg[l][s-1][QUOT_BITS-2:0], ge};
                ovf_reg[l][s] <= ovf_reg[l][s-1];
                neg_reg[l][s] <= neg_reg[l][s-1];
            end
        end
    end

    for (s = 1; s < NS; s++) begin : g_ctl
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else
                v_reg[s] <= v_reg[s-1];
        end
        always_ff @(posedge clk)
        begin
            den_reg[s] <= den_reg[s-1];
            tag_reg[s] <= tag_reg[s-1];
        end
    end

    logic             ov_reg;
    logic [31:0]      oq_reg [2];
    logic [TAG_W-1:0] ot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else
            ov_reg <= v_reg[NS-1];
    end

    always_ff @(posedge clk)
    begin
        ot_reg <= tag_reg[NS-1];
        for (int k = 0; k < 2; k++)
        begin
            if (neg_reg[k][NS-1])
            begin
                if (ovf_reg[k][NS-1] || q_reg[k][NS-1] > QUOT_BITS'(SAT_NEG))
                    oq_reg[k] <= SAT_NEG;
                else
                    oq_reg[k] <= 32'(0) - q_reg[k][NS-1][31:0];
            end
            else
            begin
                if (ovf_reg[k][NS-1] || q_reg[k][NS-1] > QUOT_BITS'(SAT_POS))
                    oq_reg[k] <= SAT_POS;
                else
                    oq_reg[k] <= q_reg[k][NS-1][31:0];
            end
        end
    end

    assign out_valid = ov_reg;
    assign quot      = oq_reg;
    assign tag_out   = ot_reg;

endmodule

>>> rtl/core/iir_frequency_response_bin.sv
// Top level: complex response H = B*conj(A)/|A|^2 of an IIR filter at one bin.
// Uses iirf_pkg, iirf_trig (per tap) and iirf_div.
//
// One bin index enters per clock; busy never rises. Each item's result leaves
// on a one-cycle done strobe; the receiver cannot stall. The depth is set by the
// bin-count division (BIN_WIDTH steps for k mod 2N, 32 for the turn), the
// 30-step CORDIC and the 33-bit quotient divider, one step per stage.
// Registers are written through the cfg channel, which is always ready; write
// them only while no item is in flight.
module iir_frequency_response_bin
    import iirf_pkg::*;
#(
    parameter int NUM_TAPS   = 5,
    parameter int COEF_WIDTH = 32,
    parameter int FRAC_BITS  = 28,
    parameter int BIN_WIDTH  = 13
)(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [BIN_WIDTH-1:0]               bin_index,
    output logic                               done,
    output logic [BIN_WIDTH-1:0]               bin_out,
    output logic signed [31:0]                 resp_real,
    output logic signed [31:0]                 resp_imag,
    output logic                               denom_zero,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [$clog2(NUM_TAPS+1)-1:0]      cfg_index,
    input  logic [63:0]                        cfg_data
);

    localparam int CIW     = $clog2(NUM_TAPS + 1);
    localparam int NW      = BIN_WIDTH + 1;
    localparam int TMW     = COEF_WIDTH + TRIG_W - CORDIC_FRAC;
    localparam int SW      = COEF_WIDTH + 7;
    localparam int LO      = (SW + 1) / 2;
    localparam int HI      = SW - LO;
    localparam int PW      = 2 * SW;
    localparam int BL      = BIN_WIDTH + 1 + TRIG_LAT + 7;
    localparam int LATENCY = BL + DIV_LAT + 1;
    localparam int TAG_W   = BIN_WIDTH + 1;

    localparam int OPA [6] = '{0, 1, 1, 0, 2, 3};
    localparam int OPB [6] = '{2, 3, 2, 3, 2, 3};

    // configuration
    logic [BIN_WIDTH-1:0] bins_reg;
    logic [63:0]          pair_reg [NUM_TAPS];
    logic [BIN_WIDTH-1:0] bc_eff;
    logic [NW-1:0]        dmod;
    logic                 accept;

    assign cfg_ready = 1'b1;
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign bc_eff    = (bins_reg == '0) ? BIN_WIDTH'(1) : bins_reg;
    assign dmod      = {bc_eff, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_reg <= BIN_WIDTH'(BIN_COUNT_RESET);
            for (int j = 0; j < NUM_TAPS; j++)
                pair_reg[j] <= (j == 0) ? COEF0_RESET : 64'(0);
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CIW'(REG_BIN_COUNT))
                bins_reg <= cfg_data[BIN_WIDTH-1:0];
            for (int j = 0; j < NUM_TAPS; j++)
                if (cfg_index == CIW'(REG_COEF_BASE + j))
                    pair_reg[j] <= cfg_data;
        end
    end

    // bin index delay line up to the divider
    logic [BIN_WIDTH-1:0] bin_line_reg [BL];

    always_ff @(posedge clk)
    begin
        bin_line_reg[0] <= bin_index;
        for (int i = 1; i < BL; i++)
            bin_line_reg[i] <= bin_line_reg[i-1];
    end

    // k mod 2N, one bit per stage
    logic          km_v_reg [BIN_WIDTH];
    logic [NW-1:0] km_r_reg [BIN_WIDTH];

    genvar s;
    for (s = 0; s < BIN_WIDTH; s++) begin : g_kmod
        logic [NW-1:0]        r_in;
        logic [BIN_WIDTH-1:0] k_in;
        logic                 v_in;
        logic [NW:0]          t;
        logic                 ge;
        if (s == 0) begin : g_first
            assign r_in = '0;
            assign k_in = bin_index;
            assign v_in = accept;
        end else begin : g_rest
            assign r_in = km_r_reg[s-1];
            assign k_in = bin_line_reg[s-1];
            assign v_in = km_v_reg[s-1];
        end
        assign t  = {r_in, k_in[BIN_WIDTH-1-s]};
        assign ge = t >= (NW+1)'(dmod);
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                km_v_reg[s] <= 1'b0;
            else
                km_v_reg[s] <= v_in;
        end
        always_ff @(posedge clk)
        begin
            km_r_reg[s] <= ge ? NW'(t - (NW+1)'(dmod)) : NW'(t);
        end
    end

    // per-tap angle j*k mod 2N
    logic          n_v_reg;
    logic [NW-1:0] n_reg  [NUM_TAPS];
    logic [NW-1:0] n_next [NUM_TAPS];
    logic [NW:0]   n_acc;

    always_comb
    begin
        n_acc = '0;
        for (int j = 0; j < NUM_TAPS; j++)
        begin
            n_next[j] = n_acc[NW-1:0];
            n_acc = n_acc + (NW+1)'(km_r_reg[BIN_WIDTH-1]);
            if (n_acc >= (NW+1)'(dmod))
                n_acc = n_acc - (NW+1)'(dmod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            n_v_reg <= 1'b0;
        else
            n_v_reg <= km_v_reg[BIN_WIDTH-1];
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
    end

    // cos/sin per tap
    logic                     tr_v   [NUM_TAPS];
    logic signed [TRIG_W-1:0] tr_cos [NUM_TAPS];
    logic signed [TRIG_W-1:0] tr_sin [NUM_TAPS];
    logic [NUM_TAPS-1:0]      tr_v_all;

    genvar j;
    for (j = 0; j < NUM_TAPS; j++) begin : g_tap
        iirf_trig #(
            .BIN_WIDTH (BIN_WIDTH)
        ) u_trig (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (n_v_reg),
            .n         (n_reg[j]),
            .bc        (bc_eff),
            .out_valid (tr_v[j]),
            .cos_val   (tr_cos[j]),
            .sin_val   (tr_sin[j])
        );
        assign tr_v_all[j] = tr_v[j];
    end

    // coefficient times trig, floor by 2^30
    logic                  tm_v_reg;
    logic signed [TMW-1:0] tm_bc_reg [NUM_TAPS];
    logic signed [TMW-1:0] tm_bs_reg [NUM_TAPS];
    logic signed [TMW-1:0] tm_ac_reg [NUM_TAPS];
    logic signed [TMW-1:0] tm_as_reg [NUM_TAPS];

    for (j = 0; j < NUM_TAPS; j++) begin : g_term
        logic signed [COEF_WIDTH-1:0]        cb, ca;
        logic signed [COEF_WIDTH+TRIG_W-1:0] pbc, pbs, pac, pas;
        assign cb  = $signed(pair_reg[j][32 +: COEF_WIDTH]);
        assign ca  = $signed(pair_reg[j][0 +: COEF_WIDTH]);
        assign pbc = cb * tr_cos[j];
        assign pbs = cb * tr_sin[j];
        assign pac = ca * tr_cos[j];
        assign pas = ca * tr_sin[j];
        always_ff @(posedge clk)
        begin
            tm_bc_reg[j] <= pbc[COEF_WIDTH+TRIG_W-1:CORDIC_FRAC];
            tm_bs_reg[j] <= pbs[COEF_WIDTH+TRIG_W-1:CORDIC_FRAC];
            tm_ac_reg[j] <= pac[COEF_WIDTH+TRIG_W-1:CORDIC_FRAC];
            tm_as_reg[j] <= pas[COEF_WIDTH+TRIG_W-1:CORDIC_FRAC];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tm_v_reg <= 1'b0;
        else
            tm_v_reg <= &tr_v_all;
    end

    // B and A sums
    logic                 sm_v_reg;
    logic signed [SW-1:0] sm_reg [4];
    logic signed [SW-1:0] sm_next [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            sm_next[k] = '0;
        for (int t = 0; t < NUM_TAPS; t++)
        begin
            sm_next[0] = sm_next[0] + SW'(tm_bc_reg[t]);
            sm_next[1] = sm_next[1] - SW'(tm_bs_reg[t]);
            sm_next[2] = sm_next[2] + SW'(tm_ac_reg[t]);
            sm_next[3] = sm_next[3] - SW'(tm_as_reg[t]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sm_v_reg <= 1'b0;
        else
            sm_v_reg <= tm_v_reg;
    end

    always_ff @(posedge clk)
    begin
        sm_reg <= sm_next;
    end

    // sign and magnitude
    logic          mg_v_reg;
    logic [SW-1:0] mg_mag_reg [4];
    logic [3:0]    mg_neg_reg;
    logic          mg_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mg_v_reg <= 1'b0;
        else
            mg_v_reg <= sm_v_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            mg_neg_reg[k] <= sm_reg[k][SW-1];
            mg_mag_reg[k] <= sm_reg[k][SW-1] ? SW'(-sm_reg[k]) : SW'(sm_reg[k]);
        end
        mg_zero_reg <= (sm_reg[2] == '0) && (sm_reg[3] == '0);
    end

    // partial products
    logic                 pp_v_reg;
    logic [2*LO-1:0]      pp_ll_reg [6];
    logic [LO+HI-1:0]     pp_lh_reg [6];
    logic [LO+HI-1:0]     pp_hl_reg [6];
    logic [2*HI-1:0]      pp_hh_reg [6];
    logic [5:0]           pp_sign_reg;
    logic                 pp_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pp_v_reg <= 1'b0;
        else
            pp_v_reg <= mg_v_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
        begin
            pp_ll_reg[k] <= mg_mag_reg[OPA[k]][LO-1:0] * mg_mag_reg[OPB[k]][LO-1:0];
            pp_lh_reg[k] <= mg_mag_reg[OPA[k]][LO-1:0] * mg_mag_reg[OPB[k]][SW-1:LO];
            pp_hl_reg[k] <= mg_mag_reg[OPA[k]][SW-1:LO] * mg_mag_reg[OPB[k]][LO-1:0];
            pp_hh_reg[k] <= mg_mag_reg[OPA[k]][SW-1:LO] * mg_mag_reg[OPB[k]][SW-1:LO];
        end
        pp_sign_reg[0] <= mg_neg_reg[0] ^ mg_neg_reg[2];
        pp_sign_reg[1] <= mg_neg_reg[1] ^ mg_neg_reg[3];
        pp_sign_reg[2] <= mg_neg_reg[1] ^ mg_neg_reg[2];
        pp_sign_reg[3] <= !(mg_neg_reg[0] ^ mg_neg_reg[3]);
        pp_sign_reg[4] <= 1'b0;
        pp_sign_reg[5] <= 1'b0;
        pp_zero_reg    <= mg_zero_reg;
    end

    // full products
    logic          pr_v_reg;
    logic [PW-1:0] pr_p_reg [6];
    logic [5:0]    pr_sign_reg;
    logic          pr_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pr_v_reg <= 1'b0;
        else
            pr_v_reg <= pp_v_reg;
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 6; k++)
            pr_p_reg[k] <= (PW'(pp_hh_reg[k]) << (2 * LO))
                         + ((PW'(pp_lh_reg[k]) + PW'(pp_hl_reg[k])) << LO)
                         + PW'(pp_ll_reg[k]);
        pr_sign_reg <= pp_sign_reg;
        pr_zero_reg <= pp_zero_reg;
    end

    // numerators and denominator
    logic                   cb_v_reg;
    logic signed [PW+1:0]   cb_re_reg;
    logic signed [PW+1:0]   cb_im_reg;
    logic [PW:0]            cb_den_reg;
    logic                   cb_zero_reg;
    logic signed [PW+1:0]   cb_term [4];

    always_comb
    begin
        for (int k = 0; k < 4; k++)
            cb_term[k] = pr_sign_reg[k] ? -$signed({2'b00, pr_p_reg[k]})
                                        : $signed({2'b00, pr_p_reg[k]});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cb_v_reg <= 1'b0;
        else
            cb_v_reg <= pr_v_reg;
    end

    always_ff @(posedge clk)
    begin
        cb_re_reg   <= cb_term[0] + cb_term[1];
        cb_im_reg   <= cb_term[2] + cb_term[3];
        cb_den_reg  <= (PW+1)'(pr_p_reg[4]) + (PW+1)'(pr_p_reg[5]);
        cb_zero_reg <= pr_zero_reg;
    end

    // sign split before the divider
    logic          sa_v_reg;
    logic [1:0]    sa_neg_reg;
    logic [PW+1:0] sa_num_reg [2];
    logic [PW:0]   sa_den_reg;
    logic          sa_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sa_v_reg <= 1'b0;
        else
            sa_v_reg <= cb_v_reg;
    end

    always_ff @(posedge clk)
    begin
        sa_neg_reg[0] <= cb_re_reg[PW+1];
        sa_neg_reg[1] <= cb_im_reg[PW+1];
        sa_num_reg[0] <= cb_re_reg[PW+1] ? (PW+2)'(-cb_re_reg) : (PW+2)'(cb_re_reg);
        sa_num_reg[1] <= cb_im_reg[PW+1] ? (PW+2)'(-cb_im_reg) : (PW+2)'(cb_im_reg);
        sa_den_reg    <= cb_den_reg;
        sa_zero_reg   <= cb_zero_reg;
    end

    // quotient
    logic             dv_valid;
    logic [31:0]      dv_quot [2];
    logic [TAG_W-1:0] dv_tag;

    iirf_div #(
        .NUM_W     (PW + 2),
        .DEN_W     (PW + 1),
        .FRAC_BITS (FRAC_BITS),
        .TAG_W     (TAG_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sa_v_reg),
        .neg       (sa_neg_reg),
        .num       (sa_num_reg),
        .den       (sa_den_reg),
        .tag_in    ({bin_line_reg[BL-1], sa_zero_reg}),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .tag_out   (dv_tag)
    );

    // result register
    logic                 done_reg;
    logic [BIN_WIDTH-1:0] bin_reg;
    logic [31:0]          re_reg;
    logic [31:0]          im_reg;
    logic                 zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= dv_tag[TAG_W-1:1];
        zero_reg <= dv_tag[0];
        re_reg   <= dv_tag[0] ? 32'(0) : dv_quot[0];
        im_reg   <= dv_tag[0] ? 32'(0) : dv_quot[1];
    end

    assign done       = done_reg;
    assign bin_out    = bin_reg;
    assign resp_real  = $signed(re_reg);
    assign resp_imag  = $signed(im_reg);
    assign denom_zero = zero_reg;

endmodule

>>> rtl/core/iirf_chk.sv
// Port-level checks for iir_frequency_response_bin, attached by bind.
// Depends on the top level's fixed latency.
module iirf_chk #(
    parameter int NUM_TAPS  = 5,
    parameter int BIN_WIDTH = 13,
    parameter int LATENCY   = 121
)(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [BIN_WIDTH-1:0]          bin_index,
    input logic                          done,
    input logic [BIN_WIDTH-1:0]          bin_out,
    input logic signed [31:0]            resp_real,
    input logic signed [31:0]            resp_imag,
    input logic                          denom_zero,
    input logic                          cfg_valid,
    input logic                          cfg_ready,
    input logic [$clog2(NUM_TAPS+1)-1:0] cfg_index,
    input logic [63:0]                   cfg_data
);

    a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("accepted item produced no result");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result without an accepted item");

    a_bin_echo: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> bin_out == $past(bin_index, LATENCY))
        else $error("bin echo mismatch");

    a_zero_resp: assert property (@(posedge clk) disable iff (!rst_n)
        done && denom_zero |-> resp_real == 32'sd0 && resp_imag == 32'sd0)
        else $error("nonzero response with zero denominator");

endmodule

bind iir_frequency_response_bin iirf_chk #(
    .NUM_TAPS  (NUM_TAPS),
    .BIN_WIDTH (BIN_WIDTH),
    .LATENCY   (LATENCY)
) u_iirf_chk (.*);
